// ===== design/rbsa_pkg.sv =====
// ----------------------------------------------------------------------------
// rbsa_pkg - shared definitions of the ring buffer space allocator
// field widths, status codes and controller states
// ----------------------------------------------------------------------------
package rbsa_pkg;

	localparam int RING_ADDR_BITS_DEF = 16;
	localparam int SIZE_W             = 17;
	localparam int ALIGN_W            = 17;
	localparam int FPOS_W             = 16;
	localparam int OFFS_W             = 16;
	localparam int STATUS_W           = 2;
	localparam int RING_RESET         = 65536;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK         = 2'd0,
		STATUS_ALLOC_FAIL = 2'd1,
		STATUS_FREE_RANGE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_POS,
		ST_EXEC
	} state_t;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

endpackage

// ===== design/ring_buffer_space_allocator.sv =====
// ----------------------------------------------------------------------------
// ring_buffer_space_allocator - aligned region allocator over a circular buffer
// head/tail bookkeeping with in-order release and bit-serial alignment rounding
// ----------------------------------------------------------------------------
// An allocate beat asks for alloc_size units starting at a multiple of
// alloc_alignment (0 counts as 1); the region goes in front of the head, or at
// offset 0 once the ring has wrapped, and status 1 reports that it did not fit.
// A free beat moves the tail to free_position, empties the ring when that
// equals the head, and gives status 2 (state untouched) when the position lies
// at or past ring_size. Writing ring_size (0 read as 1, clamped to
// 2^RING_ADDR_BITS) empties the ring; write it only while the block is idle.
// Every input beat gives exactly one result beat. An allocate passes ST_DIV,
// ST_POS and ST_EXEC on its way to the result register; in ST_POS the
// bit-serial remainder unit walks the head offset one bit per cycle to find
// head mod alignment. A free goes from ST_IDLE straight to ST_EXEC. One item
// is in work at a time, but a new item is taken while the last result still
// waits in the output register.
// ----------------------------------------------------------------------------
module ring_buffer_space_allocator
	import rbsa_pkg::*;
#(
	parameter int RING_ADDR_BITS = RING_ADDR_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration: ring_size
	input  logic                cfg_wr_en,
	input  logic [SIZE_W-1:0]   cfg_wr_data,
	// input beats
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [55:0]         s_axis_tdata,  // alloc_size[16:0], alloc_alignment[33:17],
	                                           // free_position[49:34], zero[55:50]
	input  logic                s_axis_tuser,  // func
	// result beats
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [OFFS_W-1:0]   m_axis_tdata,  // region_offset[15:0]
	output logic [STATUS_W-1:0] m_axis_tuser   // status[1:0]
);

	// offsets need RING_ADDR_BITS + 1 bits to hold the full ring length
	localparam int RW   = RING_ADDR_BITS + 1;
	// compare width: covers aligned head plus size without overflow
	localparam int CW   = ((RW > SIZE_W + 1) ? RW : SIZE_W + 1) + 1;
	localparam logic [CW-1:0] MAX_RING  = CW'(1) << RING_ADDR_BITS;
	localparam logic [CW-1:0] RST_FULL  = CW'(RING_RESET);
	localparam logic [CW-1:0] RST_RING  = (RST_FULL > MAX_RING) ? MAX_RING : RST_FULL;

	// ring state
	logic [RW-1:0]      ring_q;
	logic [RW-1:0]      head_q;
	logic [RW-1:0]      tail_q;

	// accepted item
	logic               func_q;
	logic [SIZE_W-1:0]  size_q;
	logic [ALIGN_W-1:0] align_q;
	logic [FPOS_W-1:0]  fpos_q;
	logic [CW-1:0]      pos_q;

	// output register
	logic               out_vld_q;
	logic [OFFS_W-1:0]  out_offs_q;
	status_t            out_stat_q;

	state_t             state_q, state_d;
	logic               accept;
	logic               div_start;
	logic               div_done;
	logic [ALIGN_W-1:0] div_rem;
	logic               out_free;
	logic               commit;

	logic [SIZE_W-1:0]  in_size;
	logic [ALIGN_W-1:0] in_align;
	logic [FPOS_W-1:0]  in_fpos;

	// wide views for the decision
	logic [CW-1:0]      head_w, tail_w, ring_w, size_w, fpos_w, end_w, cfg_w;
	logic [CW-1:0]      cfg_size;

	// execution results
	status_t            res_stat;
	logic [OFFS_W-1:0]  res_offs;
	logic               upd_head, upd_tail, res_empty;
	logic [RW-1:0]      new_head, new_tail;

	assign in_size  = s_axis_tdata[16:0];
	assign in_align = s_axis_tdata[33:17];
	assign in_fpos  = s_axis_tdata[49:34];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_vld_q || m_axis_tready;

	// head mod alignment, one head bit per cycle
	rbsa_rem_serial #(
		.DVD_W(RW)
	) u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (head_q),
		.divisor   (align_q),
		.done      (div_done),
		.remainder (div_rem)
	);

	// controller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		commit    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (s_axis_tuser == FUNC_FREE) begin
						state_d = ST_EXEC;
					end else begin
						state_d = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				// start the remainder unit with the latched alignment
				div_start = 1'b1;
				state_d   = ST_POS;
			end
			ST_POS: begin
				if (div_done) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				// hold until the output register can take the result
				if (out_free) begin
					commit  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// item capture and aligned position
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= s_axis_tuser;
			size_q  <= in_size;
			align_q <= (in_align == '0) ? ALIGN_W'(1) : in_align;
			fpos_q  <= in_fpos;
		end
		// round head up: add (align - rem) unless already aligned
		if (state_q == ST_POS && div_done) begin
			if (div_rem == '0) begin
				pos_q <= head_w;
			end else begin
				pos_q <= head_w + CW'(align_q) - CW'(div_rem);
			end
		end
	end

	assign head_w = CW'(head_q);
	assign tail_w = CW'(tail_q);
	assign ring_w = CW'(ring_q);
	assign size_w = CW'(size_q);
	assign fpos_w = CW'(fpos_q);
	assign end_w  = pos_q + size_w;
	assign cfg_w  = CW'(cfg_wr_data);

	// ring_size write: zero reads as one, clamp to the address space
	always_comb begin
		if (cfg_w == '0) begin
			cfg_size = CW'(1);
		end else if (cfg_w > MAX_RING) begin
			cfg_size = MAX_RING;
		end else begin
			cfg_size = cfg_w;
		end
	end

	// decision for the item in hand
	always_comb begin
		res_stat  = STATUS_OK;
		res_offs  = '0;
		upd_head  = 1'b0;
		upd_tail  = 1'b0;
		res_empty = 1'b0;
		new_head  = end_w[RW-1:0];
		new_tail  = fpos_w[RW-1:0];
		if (func_q == FUNC_FREE) begin
			if (fpos_w >= ring_w) begin
				res_stat = STATUS_FREE_RANGE;
			end else if (fpos_w == head_w) begin
				res_empty = 1'b1;
			end else begin
				upd_tail = 1'b1;
			end
		end else if (size_q == '0) begin
			res_stat = STATUS_ALLOC_FAIL;
		end else if (head_w <= tail_w) begin
			// unwrapped: free space runs from head to tail
			if (end_w > tail_w) begin
				res_stat = STATUS_ALLOC_FAIL;
			end else begin
				upd_head = 1'b1;
				res_offs = pos_q[OFFS_W-1:0];
			end
		end else if (end_w <= ring_w) begin
			// wrapped, region fits before the ring end
			upd_head = 1'b1;
			res_offs = pos_q[OFFS_W-1:0];
		end else if (size_w > tail_w) begin
			res_stat = STATUS_ALLOC_FAIL;
		end else begin
			// wrapped, place region at the ring start
			upd_head = 1'b1;
			new_head = size_w[RW-1:0];
		end
	end

	// ring state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_q <= RST_RING[RW-1:0];
			head_q <= '0;
			tail_q <= RST_RING[RW-1:0];
		end else if (cfg_wr_en) begin
			ring_q <= cfg_size[RW-1:0];
			head_q <= '0;
			tail_q <= cfg_size[RW-1:0];
		end else if (commit) begin
			if (res_empty) begin
				head_q <= '0;
				tail_q <= ring_q;
			end
			if (upd_head) begin
				head_q <= new_head;
			end
			if (upd_tail) begin
				tail_q <= new_tail;
			end
		end
	end

	// output register, refilled as soon as the waiting beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (commit) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_stat_q <= res_stat;
			out_offs_q <= res_offs;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_offs_q;
	assign m_axis_tuser  = out_stat_q;

endmodule

// ===== design/rbsa_rem_serial.sv =====
// ----------------------------------------------------------------------------
// rbsa_rem_serial - bit-serial remainder unit
// restoring division, one dividend bit per cycle, yields dividend mod divisor
// ----------------------------------------------------------------------------
module rbsa_rem_serial
	import rbsa_pkg::*;
#(
	parameter int DVD_W = RING_ADDR_BITS_DEF + 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DVD_W-1:0]   dividend,
	input  logic [ALIGN_W-1:0] divisor,
	output logic               done,
	output logic [ALIGN_W-1:0] remainder
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [DVD_W-1:0]   dvd_q;
	logic [ALIGN_W-1:0] dsr_q;
	logic [ALIGN_W-1:0] rem_q;

	logic [ALIGN_W:0]   trial;
	logic [ALIGN_W:0]   diff;
	logic               fits;

	// shift in the next dividend bit and subtract when the divisor fits
	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			rem_q <= fits ? diff[ALIGN_W-1:0] : trial[ALIGN_W-1:0];
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

// ===== bench/ring_buffer_space_allocator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_buffer_space_allocator_test - self-checking bench of the ring allocator
// a directed table of corner cases, then random alloc/free traffic over
// several ring sizes and idle patterns, scored against an in-bench predictor
// ----------------------------------------------------------------------------
module ring_buffer_space_allocator_test;
	import rbsa_pkg::*;

	localparam int STALL_LIMIT = 5000;   // cycles with no beat on either side
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 166;
	localparam int DIR_ROWS    = 25;

	// one request beat as seen on the input side
	typedef struct {
		logic               func;
		logic [SIZE_W-1:0]  size;
		logic [ALIGN_W-1:0] align;
		logic [FPOS_W-1:0]  fpos;
	} request_t;

	// one result beat
	typedef struct {
		status_t             status;
		logic [OFFS_W-1:0]   offset;
	} alloc_result_t;

	// directed row: optional ring_size write, the request, and a typed-in
	// result where it is obvious (known = 1)
	typedef struct {
		logic               load;
		logic [SIZE_W-1:0]  ring;
		logic               func;
		logic [SIZE_W-1:0]  size;
		logic [ALIGN_W-1:0] align;
		logic [FPOS_W-1:0]  fpos;
		logic               known;
		status_t            status;
		logic [OFFS_W-1:0]  offset;
	} plan_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wr_en = 1'b0;
	logic [SIZE_W-1:0]   cfg_wr_data = '0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [55:0]         s_axis_tdata = '0;   // alloc_size[16:0], alloc_alignment[33:17],
	                                         // free_position[49:34], zero[55:50]
	logic                s_axis_tuser = 1'b0; // func
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [OFFS_W-1:0]   m_axis_tdata;        // region_offset[15:0]
	logic [STATUS_W-1:0] m_axis_tuser;        // status[1:0]

	// predictor state: ring length, head and tail offsets
	int unsigned ring_len;
	int unsigned head_pos;
	int unsigned tail_pos;

	alloc_result_t pending_results[$];   // results owed by the block, oldest first
	int unsigned   live_starts[$];       // starts of regions not yet released
	int            mismatches = 0;
	int            stall_pct = 0;        // receiver back-pressure, percent of cycles
	int            quiet_cycles = 0;
	alloc_result_t seen_want;

	// corner cases; rows without a typed-in result are left to the predictor
	plan_row_t directed [DIR_ROWS] = '{
		// zero size fails right after reset
		'{1'b0, 17'd0, FUNC_ALLOC, 17'd0,     17'd1,     16'd0,     1'b1, STATUS_ALLOC_FAIL, 16'd0},
		// free at the head empties the ring
		'{1'b0, 17'd0, FUNC_FREE,  17'd0,     17'd0,     16'd0,     1'b1, STATUS_OK,         16'd0},
		'{1'b0, 17'd0, FUNC_ALLOC, 17'd100,   17'd0,     16'd0,     1'b0, STATUS_OK,         16'd0},
		'{1'b0, 17'd0, FUNC_ALLOC, 17'd10,    17'd64,    16'd0,     1'b0, STATUS_OK,         16'd0},
		// huge alignment rounds the head past the ring
		'{1'b0, 17'd0, FUNC_ALLOC, 17'd1,     17'd65536, 16'd0,     1'b1, STATUS_ALLOC_FAIL, 16'd0},
		'{1'b0, 17'd0, FUNC_ALLOC, 17'd65536, 17'd1,     16'd0,     1'b1, STATUS_ALLOC_FAIL, 16'd0},
		'{1'b0, 17'd0, FUNC_FREE,  17'd0,     17'd0,     16'd100,   1'b0, STATUS_OK,         16'd0},
		'{1'b0, 17'd0, FUNC_ALLOC, 17'd50,    17'd1,     16'd0,     1'b0, STATUS_OK,         16'd0},
		// wrapped, no room at the top nor below the tail
		'{1'b0, 17'd0, FUNC_ALLOC, 17'd65400, 17'd1,     16'd0,     1'b1, STATUS_ALLOC_FAIL, 16'd0},
		// wrapped, goes back to offset zero
		'{1'b0, 17'd0, FUNC_ALLOC, 17'd90,    17'd65536, 16'd0,     1'b0, STATUS_OK,         16'd0},
		'{1'b0, 17'd0, FUNC_ALLOC, 17'd10,    17'd0,     16'd0,     1'b0, STATUS_OK,         16'd0},
		// head sits on the tail
		'{1'b0, 17'd0, FUNC_ALLOC, 17'd1,     17'd1,     16'd0,     1'b1, STATUS_ALLOC_FAIL, 16'd0},
		'{1'b0, 17'd0, FUNC_FREE,  17'd0,     17'd0,     16'd65535, 1'b0, STATUS_OK,         16'd0},
		'{1'b0, 17'd0, FUNC_FREE,  17'd0,     17'd0,     16'd100,   1'b0, STATUS_OK,         16'd0},
		// whole ring in one region
		'{1'b0, 17'd0, FUNC_ALLOC, 17'd65536, 17'd3,     16'd0,     1'b0, STATUS_OK,         16'd0},
		'{1'b0, 17'd0, FUNC_ALLOC, 17'd1,     17'd0,     16'd0,     1'b1, STATUS_ALLOC_FAIL, 16'd0},
		'{1'b0, 17'd0, FUNC_FREE,  17'd0,     17'd0,     16'd65535, 1'b0, STATUS_OK,         16'd0},
		'{1'b0, 17'd0, FUNC_ALLOC, 17'd65535, 17'd1,     16'd0,     1'b0, STATUS_OK,         16'd0},
		'{1'b0, 17'd0, FUNC_FREE,  17'd0,     17'd0,     16'd0,     1'b0, STATUS_OK,         16'd0},
		// last unit of the ring
		'{1'b0, 17'd0, FUNC_ALLOC, 17'd1,     17'd1,     16'd0,     1'b0, STATUS_OK,         16'd0},
		'{1'b0, 17'd0, FUNC_ALLOC, 17'd1,     17'd1,     16'd0,     1'b1, STATUS_ALLOC_FAIL, 16'd0},
		// ring_size 0 reads as 1, so position 1 is out of range
		'{1'b1, 17'd0, FUNC_FREE,  17'd0,     17'd0,     16'd1,     1'b1, STATUS_FREE_RANGE, 16'd0},
		'{1'b0, 17'd0, FUNC_ALLOC, 17'd1,     17'd0,     16'd0,     1'b0, STATUS_OK,         16'd0},
		'{1'b0, 17'd0, FUNC_ALLOC, 17'd1,     17'd1,     16'd0,     1'b1, STATUS_ALLOC_FAIL, 16'd0},
		// oversized ring_size clamps to the full ring
		'{1'b1, 17'h1FFFF, FUNC_FREE, 17'd0,  17'd0,     16'd65535, 1'b0, STATUS_OK,         16'd0}
	};

	logic [SIZE_W-1:0] ring_plan [PHASES] = '{
		17'd65536, 17'd257, 17'd1, 17'd4096, 17'd0, 17'd37, 17'h1FFFF, 17'd0
	};

	ring_buffer_space_allocator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #1 clk = ~clk;

	// ring_size write: 0 reads as 1, anything past the full ring is clamped
	function automatic void reset_ring(logic [SIZE_W-1:0] value);
		int unsigned len;
		len = value;
		if (len == 0) len = 1;
		if (len > RING_RESET) len = RING_RESET;
		ring_len = len;
		head_pos = 0;
		tail_pos = len;
	endfunction

	// expected outcome of one request; moves head/tail as the block should
	function automatic alloc_result_t apply_request(request_t req);
		alloc_result_t res;
		int unsigned   sz;
		int unsigned   step;
		int unsigned   pos;
		int unsigned   fp;
		sz = req.size;
		fp = req.fpos;
		step = (req.align == 0) ? 1 : req.align;
		res.status = STATUS_OK;
		res.offset = '0;
		if (req.func == FUNC_FREE) begin
			if (fp >= ring_len)
				res.status = STATUS_FREE_RANGE;
			else if (fp == head_pos) begin
				// released up to the head: ring is empty again
				head_pos = 0;
				tail_pos = ring_len;
			end else
				tail_pos = fp;
		end else begin
			// aligned head at full precision, may overshoot the ring
			pos = ((head_pos + step - 1) / step) * step;
			if (sz == 0)
				res.status = STATUS_ALLOC_FAIL;
			else if (head_pos <= tail_pos) begin
				if (pos + sz > tail_pos)
					res.status = STATUS_ALLOC_FAIL;
				else begin
					head_pos = pos + sz;
					res.offset = pos[OFFS_W-1:0];
				end
			end else if (pos + sz <= ring_len) begin
				head_pos = pos + sz;
				res.offset = pos[OFFS_W-1:0];
			end else if (sz > tail_pos)
				res.status = STATUS_ALLOC_FAIL;
			else begin
				// wrap to the bottom of the ring
				head_pos = sz;
			end
		end
		return res;
	endfunction

	// drive one request and hold it until taken; the prediction is made at
	// the accepting edge, a typed-in result overrides what gets scored
	task automatic send_request(input request_t req, input logic known,
		input alloc_result_t want, output alloc_result_t got);
		s_axis_tdata  <= {6'b0, req.fpos, req.align, req.size};
		s_axis_tuser  <= req.func;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		got = apply_request(req);
		pending_results.push_back(known ? want : got);
	endtask

	// ring_size only changes with the block drained and no beat offered
	task automatic load_ring(input logic [SIZE_W-1:0] value);
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		reset_ring(value);
	endtask

	// receiver back-pressure
	always @(posedge clk)
		m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);

	// result scoreboard: every result beat against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result beat: status %0d offset %0d",
						m_axis_tuser, m_axis_tdata);
				mismatches++;
			end else begin
				seen_want = pending_results.pop_front();
				if (m_axis_tuser !== seen_want.status || m_axis_tdata !== seen_want.offset) begin
					if (mismatches < 10)
						$display("result mismatch: status %0d/%0d offset %0d/%0d (expected/actual)",
							seen_want.status, m_axis_tuser, seen_want.offset, m_axis_tdata);
					mismatches++;
				end
			end
		end
	end

	// watchdog: ends a hung run
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == STALL_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		request_t      req;
		alloc_result_t want;
		alloc_result_t got;
		int            idle_pct;
		int unsigned   pick;
		int            drop;

		reset_ring(17'(RING_RESET));
		idle_pct = 0;
		want.status = STATUS_OK;
		want.offset = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed corner cases, back to back
		for (int i = 0; i < DIR_ROWS; i++) begin
			req.func    = directed[i].func;
			req.size    = directed[i].size;
			req.align   = directed[i].align;
			req.fpos    = directed[i].fpos;
			want.status = directed[i].status;
			want.offset = directed[i].offset;
			if (directed[i].load)
				load_ring(directed[i].ring);
			send_request(req, directed[i].known, want, got);
		end

		// random traffic: mostly in-order alloc/free of live regions, plus noise
		for (int p = 0; p < PHASES; p++) begin
			load_ring((p == PHASES - 1) ? 17'($urandom_range(1, RING_RESET)) : ring_plan[p]);
			live_starts.delete();
			case (p % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 87; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 87; end
				default: begin idle_pct = 12; stall_pct = 12; end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// unused fields carry noise
				req.size  = 17'($urandom);
				req.align = 17'($urandom);
				req.fpos  = 16'($urandom);
				pick = $urandom_range(0, 99);
				if (pick < 60) begin
					req.func = FUNC_ALLOC;
					pick = $urandom_range(0, 99);
					if (pick < 80)      req.size = 17'($urandom_range(1, (ring_len + 3) / 4));
					else if (pick < 88) req.size = 17'($urandom_range(1, ring_len));
					else if (pick < 92) req.size = 17'(RING_RESET);
					else if (pick < 95) req.size = '0;
					else                req.size = 17'($urandom_range(0, RING_RESET));
					pick = $urandom_range(0, 99);
					if (pick < 20)      req.align = '0;
					else if (pick < 40) req.align = 17'd1;
					else if (pick < 70) req.align = 17'(1 << $urandom_range(1, 8));
					else if (pick < 90) req.align = 17'($urandom_range(2, 100));
					else if (pick < 97) req.align = 17'($urandom_range(0, RING_RESET));
					else                req.align = 17'(RING_RESET);
				end else if (pick < 88) begin
					// release the oldest regions, up to the next live one or the head
					req.func = FUNC_FREE;
					if (live_starts.size() >= 2 && $urandom_range(0, 3) != 0) begin
						drop = $urandom_range(1, live_starts.size() - 1);
						repeat (drop) void'(live_starts.pop_front());
						req.fpos = 16'(live_starts[0]);
					end else if (head_pos < ring_len)
						req.fpos = 16'(head_pos);
					else if (live_starts.size() != 0)
						req.fpos = 16'(live_starts[0]);
					else
						req.fpos = 16'($urandom_range(0, ring_len - 1));
				end else
					req.func = FUNC_FREE;   // any position, often out of range

				// sender hold-offs: a full drain now and then, else random gaps
				if (n == 100 || $urandom_range(0, 99) == 0) begin
					s_axis_tvalid <= 1'b0;
					do @(posedge clk); while (pending_results.size() != 0);
				end else if ($urandom_range(0, 99) < idle_pct) begin
					s_axis_tvalid <= 1'b0;
					do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
				end

				send_request(req, 1'b0, want, got);
				if (req.func == FUNC_ALLOC && got.status == STATUS_OK)
					live_starts.push_back(got.offset);
				else if (req.func == FUNC_FREE && head_pos == 0 && tail_pos == ring_len)
					live_starts.delete();
			end
		end

		// drain, then let the pipeline settle
		s_axis_tvalid <= 1'b0;
		stall_pct = 0;
		do @(posedge clk); while (pending_results.size() != 0);
		repeat (40) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
